@@ src/gmsb_pkg.sv @@
// Shared codes and control types for the grid BFS distance block.
// No dependencies; imported by every module of the block.
package gmsb_pkg;

  localparam logic [1:0] KIND_WRITE   = 2'd0;
  localparam logic [1:0] KIND_COMPUTE = 2'd1;
  localparam logic [1:0] KIND_READ    = 2'd2;
  localparam logic [1:0] KIND_NONE    = 2'd3;

  localparam logic [1:0] CODE_EMPTY   = 2'd0;
  localparam logic [1:0] CODE_HOUSE   = 2'd1;
  localparam logic [1:0] CODE_WELL    = 2'd2;
  localparam logic [1:0] CODE_BLOCKED = 2'd3;

  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  localparam logic [13:0] RES_UNREACHED = 14'h3FFF;
  localparam logic [11:0] LEVEL_MAX     = 12'hFFF;

  typedef struct packed {
    logic load;
    logic shift;
  } chain_ctl_t;

endpackage

@@ src/gmsb_cand_cell.sv @@
// One cell of the neighbor candidate chain: holds one candidate cell position.
// Depends on gmsb_pkg for the chain control struct.
module gmsb_cand_cell #(
  parameter int RW = 6,
  parameter int CW = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gmsb_pkg::chain_ctl_t ctl_i,
  input  logic                ld_valid_i,
  input  logic [RW-1:0]       ld_row_i,
  input  logic [CW-1:0]       ld_col_i,
  input  logic                nx_valid_i,
  input  logic [RW-1:0]       nx_row_i,
  input  logic [CW-1:0]       nx_col_i,
  output logic                valid_o,
  output logic [RW-1:0]       row_o,
  output logic [CW-1:0]       col_o
);
  import gmsb_pkg::*;

  logic          valid_q;
  logic [RW-1:0] row_q;
  logic [CW-1:0] col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.load) begin
      valid_q <= ld_valid_i;
    end else if (ctl_i.shift) begin
      valid_q <= nx_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      row_q <= ld_row_i;
      col_q <= ld_col_i;
    end else if (ctl_i.shift) begin
      row_q <= nx_row_i;
      col_q <= nx_col_i;
    end
  end

  assign valid_o = valid_q;
  assign row_o   = row_q;
  assign col_o   = col_q;

endmodule

@@ src/grid_multi_source_bfs_distance.sv @@
// Top level of the multi-source grid BFS distance block: sequencer, memories.
// Depends on gmsb_pkg and gmsb_cand_cell.
//
// channel | direction | signals
// --------+-----------+---------------------------------------------------
// in      | input     | in_valid_i, in_stall_o, kind_i, row_i, col_i, cell_code_i
// out     | output    | out_valid_o, out_stall_i, distance_value_o
// cfg     | input     | cfg_we_i, cfg_addr_i, cfg_wdata_i
//
// A read passes through the registered memory read, then the output register.
// A compute sweeps all 2^(RW+CW) addresses once, then pops each queued cell and tries
// each slot of the four-cell candidate chain in turn, with a level step between levels.
// Reset clears the sequencer, queue pointers and output valid; memories keep no reset.
// The output register holds while stalled; a read waits for it to free.
module grid_multi_source_bfs_distance #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [5:0]  row_i,
  input  logic [5:0]  col_i,
  input  logic [1:0]  cell_code_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [13:0] distance_value_o,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [6:0]  cfg_wdata_i
);
  import gmsb_pkg::*;

  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AW    = RW + CW;
  localparam int DEPTH = 1 << AW;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_READ  = 4'd1;
  localparam logic [3:0] ST_INIT  = 4'd2;
  localparam logic [3:0] ST_LEVEL = 4'd3;
  localparam logic [3:0] ST_POP   = 4'd4;
  localparam logic [3:0] ST_POPW  = 4'd5;
  localparam logic [3:0] ST_CEN   = 4'd6;
  localparam logic [3:0] ST_NB    = 4'd7;
  localparam logic [3:0] ST_NBW   = 4'd8;

  logic [3:0]  state_q, state_d;
  logic [6:0]  rows_q, cols_q;
  logic [AW:0] sweep_q, sweep_d;
  logic        sv_q, sv_d;
  logic [AW-1:0] sa_q, sa_d;
  logic [AW:0] head_q, head_d, tail_q, tail_d, lend_q, lend_d;
  logic [11:0] level_q, level_d;
  logic [2:0]  nb_cnt_q, nb_cnt_d;
  logic        out_v_q, out_v_d;
  logic [13:0] out_q, out_d;
  logic        rd_in_q, rd_in_d;
  logic [AW-1:0] rd_addr_q, rd_addr_d;

  // memories
  logic [1:0]  cell_mem [DEPTH];
  logic        vis_mem  [DEPTH];
  logic [13:0] res_mem  [DEPTH];
  logic [AW-1:0] q_mem  [DEPTH];

  logic          cm_we;  logic [AW-1:0] cm_waddr, cm_raddr; logic [1:0] cm_wdata, cm_rdata_q;
  logic          vm_we;  logic [AW-1:0] vm_waddr, vm_raddr; logic vm_wdata, vm_rdata_q;
  logic          rm_we;  logic [AW-1:0] rm_waddr, rm_raddr; logic [13:0] rm_wdata, rm_rdata_q;
  logic          qm_we;  logic [AW-1:0] qm_waddr, qm_raddr, qm_wdata, qm_rdata_q;

  always_ff @(posedge clk_i) begin
    if (cm_we) cell_mem[cm_waddr] <= cm_wdata;
    cm_rdata_q <= cell_mem[cm_raddr];
  end
  always_ff @(posedge clk_i) begin
    if (vm_we) vis_mem[vm_waddr] <= vm_wdata;
    vm_rdata_q <= vis_mem[vm_raddr];
  end
  always_ff @(posedge clk_i) begin
    if (rm_we) res_mem[rm_waddr] <= rm_wdata;
    rm_rdata_q <= res_mem[rm_raddr];
  end
  always_ff @(posedge clk_i) begin
    if (qm_we) q_mem[qm_waddr] <= qm_wdata;
    qm_rdata_q <= q_mem[qm_raddr];
  end

  // input address and range check
  logic          in_inside;
  logic [AW-1:0] in_addr;
  assign in_inside = (11'(row_i) < 11'(MAX_ROWS)) && (11'(col_i) < 11'(MAX_COLS));
  assign in_addr   = {RW'(row_i), CW'(col_i)};

  // sweep stage
  logic [RW-1:0] s_r;
  logic [CW-1:0] s_c;
  logic          s_act;
  assign s_r   = sa_q[AW-1:CW];
  assign s_c   = sa_q[CW-1:0];
  assign s_act = (11'(s_r) < 11'(rows_q)) && (11'(s_r) < 11'(MAX_ROWS)) &&
                 (11'(s_c) < 11'(cols_q)) && (11'(s_c) < 11'(MAX_COLS));

  // neighbor candidates of the popped cell
  logic [RW-1:0] p_r;
  logic [CW-1:0] p_c;
  logic [10:0]   p_rp, p_cp;
  logic [3:0]    ld_v;
  logic [RW-1:0] ld_r [4];
  logic [CW-1:0] ld_c [4];
  assign p_r  = qm_rdata_q[AW-1:CW];
  assign p_c  = qm_rdata_q[CW-1:0];
  assign p_rp = 11'(p_r) + 11'd1;
  assign p_cp = 11'(p_c) + 11'd1;

  always_comb begin
    // right, left, up, down
    ld_v[0] = (p_cp < 11'(cols_q)) && (p_cp < 11'(MAX_COLS));
    ld_r[0] = p_r;            ld_c[0] = CW'(p_cp);
    ld_v[1] = (p_c != '0);
    ld_r[1] = p_r;            ld_c[1] = p_c - CW'(1);
    ld_v[2] = (p_r != '0);
    ld_r[2] = p_r - RW'(1);   ld_c[2] = p_c;
    ld_v[3] = (p_rp < 11'(rows_q)) && (p_rp < 11'(MAX_ROWS));
    ld_r[3] = RW'(p_rp);      ld_c[3] = p_c;
  end

  chain_ctl_t    ctl;
  logic [4:0]    ch_v;
  logic [RW-1:0] ch_r [5];
  logic [CW-1:0] ch_c [5];
  assign ch_v[4] = 1'b0;
  assign ch_r[4] = '0;
  assign ch_c[4] = '0;

  for (genvar k = 0; k < 4; k++) begin : g_chain
    gmsb_cand_cell #(.RW(RW), .CW(CW)) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .ld_valid_i (ld_v[k]),
      .ld_row_i   (ld_r[k]),
      .ld_col_i   (ld_c[k]),
      .nx_valid_i (ch_v[k+1]),
      .nx_row_i   (ch_r[k+1]),
      .nx_col_i   (ch_c[k+1]),
      .valid_o    (ch_v[k]),
      .row_o      (ch_r[k]),
      .col_o      (ch_c[k])
    );
  end

  logic [AW-1:0] cand_addr;
  logic [13:0]   doubled;
  logic          out_free;
  assign cand_addr = {ch_r[0], ch_c[0]};
  assign doubled   = {1'b0, level_q, 1'b0};
  assign out_free  = !out_v_q || !out_stall_i;

  always_comb begin
    state_d   = state_q;
    sweep_d   = sweep_q;
    sv_d      = 1'b0;
    sa_d      = sa_q;
    head_d    = head_q;
    tail_d    = tail_q;
    lend_d    = lend_q;
    level_d   = level_q;
    nb_cnt_d  = nb_cnt_q;
    rd_in_d   = rd_in_q;
    rd_addr_d = rd_addr_q;
    out_v_d   = out_v_q && out_stall_i;
    out_d     = out_q;
    ctl       = '0;
    cm_we = 1'b0; cm_waddr = in_addr; cm_wdata = cell_code_i; cm_raddr = in_addr;
    vm_we = 1'b0; vm_waddr = sa_q;    vm_wdata = 1'b0;        vm_raddr = cand_addr;
    rm_we = 1'b0; rm_waddr = sa_q;    rm_wdata = 14'd0;       rm_raddr = in_addr;
    qm_we = 1'b0; qm_waddr = tail_q[AW-1:0]; qm_wdata = sa_q; qm_raddr = head_q[AW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (kind_i)
            KIND_WRITE: cm_we = in_inside;
            KIND_COMPUTE: begin
              sweep_d = '0;
              head_d  = '0;
              tail_d  = '0;
              level_d = '0;
              state_d = ST_INIT;
            end
            KIND_READ: begin
              rd_in_d   = in_inside;
              rd_addr_d = in_addr;
              state_d   = ST_READ;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        // keep reading the same entry while the output register is busy
        rm_raddr = rd_addr_q;
        if (out_free) begin
          out_v_d = 1'b1;
          out_d   = rd_in_q ? rm_rdata_q : 14'd0;
          state_d = ST_IDLE;
        end
      end
      ST_INIT: begin
        cm_raddr = sweep_q[AW-1:0];
        if (sweep_q != (AW+1)'(DEPTH)) begin
          sv_d    = 1'b1;
          sa_d    = sweep_q[AW-1:0];
          sweep_d = sweep_q + 1'b1;
        end
        if (sv_q) begin
          rm_we    = 1'b1;
          rm_wdata = (s_act && cm_rdata_q == CODE_HOUSE) ? RES_UNREACHED : 14'd0;
          vm_we    = 1'b1;
          vm_wdata = s_act && cm_rdata_q == CODE_WELL;
          if (s_act && cm_rdata_q == CODE_WELL) begin
            qm_we  = 1'b1;
            tail_d = tail_q + 1'b1;
          end
        end else if (sweep_q == (AW+1)'(DEPTH)) begin
          state_d = ST_LEVEL;
        end
      end
      ST_LEVEL: begin
        if (head_q == tail_q) begin
          state_d = ST_IDLE;
        end else begin
          lend_d  = tail_q;
          state_d = ST_POP;
        end
      end
      ST_POP: begin
        if (head_q == lend_q) begin
          if (level_q != LEVEL_MAX) level_d = level_q + 1'b1;
          state_d = ST_LEVEL;
        end else begin
          head_d  = head_q + 1'b1;
          state_d = ST_POPW;
        end
      end
      ST_POPW: begin
        // hold the popped entry on the queue read port for the result write
        qm_raddr = head_q[AW-1:0] - AW'(1);
        cm_raddr = qm_rdata_q;
        ctl.load = 1'b1;
        nb_cnt_d = 3'd4;
        state_d  = ST_CEN;
      end
      ST_CEN: begin
        // popped cell code is in cm_rdata_q; queue read data still holds it
        rm_waddr = qm_rdata_q;
        rm_wdata = doubled;
        rm_we    = (cm_rdata_q == CODE_HOUSE);
        state_d  = ST_NB;
      end
      ST_NB: begin
        cm_raddr = cand_addr;
        if (nb_cnt_q == 3'd0) begin
          state_d = ST_POP;
        end else if (ch_v[0]) begin
          state_d = ST_NBW;
        end else begin
          ctl.shift = 1'b1;
          nb_cnt_d  = nb_cnt_q - 1'b1;
        end
      end
      ST_NBW: begin
        // drop visited and blocked neighbors, mark and enqueue the rest
        if (!vm_rdata_q && cm_rdata_q != CODE_BLOCKED) begin
          vm_we    = 1'b1;
          vm_waddr = cand_addr;
          vm_wdata = 1'b1;
          qm_we    = 1'b1;
          qm_wdata = cand_addr;
          tail_d   = tail_q + 1'b1;
        end
        ctl.shift = 1'b1;
        nb_cnt_d  = nb_cnt_q - 1'b1;
        state_d   = ST_NB;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rows_q   <= 7'd64;
      cols_q   <= 7'd64;
      sweep_q  <= '0;
      sv_q     <= 1'b0;
      head_q   <= '0;
      tail_q   <= '0;
      lend_q   <= '0;
      level_q  <= '0;
      nb_cnt_q <= '0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      sweep_q  <= sweep_d;
      sv_q     <= sv_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      lend_q   <= lend_d;
      level_q  <= level_d;
      nb_cnt_q <= nb_cnt_d;
      out_v_q  <= out_v_d;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          CFG_ROWS: rows_q <= cfg_wdata_i;
          CFG_COLS: cols_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sa_q      <= sa_d;
    rd_in_q   <= rd_in_d;
    rd_addr_q <= rd_addr_d;
    out_q     <= out_d;
  end

  assign in_stall_o       = (state_q != ST_IDLE);
  assign out_valid_o      = out_v_q;
  assign distance_value_o = out_q;

`ifndef ASSERT_OFF
  a_head_le_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= tail_q) else $error("queue head passed tail");
  a_enq_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qm_we |-> (tail_q < (AW+1)'(DEPTH))) else $error("queue overflow");
  a_pop_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POPW) |-> (head_q != '0)) else $error("pop without entry");
`endif

endmodule
